/* sv/tbp_pkg.sv */
// Shared types, constants and counter helpers for the tournament branch predictor.
package tbp_pkg;

  localparam int unsigned HL_W  = 4;   // width of the history length register
  localparam int unsigned CTR_W = 2;   // width of one saturating counter
  localparam int unsigned CNT_W = 32;  // width of the correct-prediction count

  typedef logic [CTR_W-1:0] ctr_t;

  localparam ctr_t CTR_MAX     = 2'd3;
  localparam ctr_t CTR_MIN     = 2'd0;
  localparam ctr_t CTR_TAKEN   = 2'd2;  // counter value at or above this predicts taken
  localparam ctr_t DIR_INIT    = 2'd3;  // strongly taken
  localparam ctr_t CHOOSE_INIT = 2'd0;  // strongly prefer gshare

  localparam logic [HL_W-1:0] HL_RESET = 4'd11;

  // Step a counter one place toward up/down, saturating at both ends.
  function automatic ctr_t ctr_train(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + ctr_t'(1);
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - ctr_t'(1);
    end
    return r;
  endfunction

  function automatic logic ctr_pred(input ctr_t c);
    return c >= CTR_TAKEN;
  endfunction

endpackage

/* sv/tbp_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
module tbp_ram #(
  parameter int unsigned DW = 2,
  parameter int unsigned AW = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tournament_branch_predictor.sv */
// Top level of the tournament (gshare vs. bimodal) branch predictor.
//
// One resolved branch is a beat on start_i/branch_address_i/outcome_taken_i,
// taken at a clock edge where start_i is high and busy_o is low. The block
// takes one beat every cycle while busy_o is low: the tables sit in two RAMs
// with registered reads (bimodal and chooser counters share a word, both
// indexed by the address; gshare has its own), and a same-entry
// read-modify-write between back-to-back branches is covered by forwarding
// the value being written. The result beat passes through the stage
// registers and then the result registers before done_o rises, and stays
// on the result ports for exactly one cycle; there is no way to hold it off.
// After reset the block runs a clearing pass that writes the initial counters
// into every entry (2**INDEX_BITS, 2048 by default), one entry a cycle, and
// busy_o stays high until it is done. cfg_we_i writes the history length at
// any edge; change it only while no branch is in flight. Lengths above
// MAX_HISTORY act as MAX_HISTORY, zero folds in no history.
module tournament_branch_predictor #(
  parameter int unsigned INDEX_BITS  = 11,
  parameter int unsigned MAX_HISTORY = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tbp_pkg::HL_W-1:0]  cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [63:0]               branch_address_i,
  input  logic                      outcome_taken_i,
  output logic                      done_o,
  output logic                      predicted_taken_o,
  output logic                      final_correct_o,
  output logic                      bimodal_correct_o,
  output logic                      gshare_correct_o,
  output logic [tbp_pkg::CNT_W-1:0] correct_total_o
);

  import tbp_pkg::*;

  localparam int unsigned HX = (INDEX_BITS > MAX_HISTORY) ? INDEX_BITS : MAX_HISTORY;
  localparam int unsigned AW = 2 * CTR_W;  // chooser and bimodal share a word

  typedef logic [INDEX_BITS-1:0] idx_t;

  // Control and configuration registers
  logic                   clearing_q, clearing_d;
  idx_t                   clr_idx_q, clr_idx_d;
  logic [HL_W-1:0]        hl_q, hl_d;
  logic [MAX_HISTORY-1:0] hist_q, hist_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   s_valid_q, s_valid_d;
  logic                   done_q, done_d;

  // Stage and forwarding payload
  idx_t          s_aidx_q, s_gidx_q;
  logic          s_taken_q;
  logic          fa_hit_q, fg_hit_q;
  logic [AW-1:0] fa_data_q;
  ctr_t          fg_data_q;
  logic          pred_q, final_q, bok_q, gok_q;

  // Front end: index computation at the accept edge
  logic                  accept;
  idx_t                  aidx, gidx, hfold;
  logic [HX-1:0]         hist_ext;

  assign accept   = start_i && !busy_o;
  assign aidx     = branch_address_i[INDEX_BITS-1:0];
  assign hist_ext = HX'(hist_q);

  // Fold in only the active history bits, newest in bit 0.
  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      hfold[i] = hist_ext[i] && (i < MAX_HISTORY) && (i < int'(hl_q));
    end
  end

  assign gidx = aidx ^ hfold;

  // Table RAMs
  logic          a_we, g_we;
  idx_t          a_waddr, g_waddr;
  logic [AW-1:0] a_wdata, a_rdata, a_cur, a_new;
  ctr_t          g_wdata, g_rdata, g_cur, g_new;

  tbp_ram #(.DW(AW), .AW(INDEX_BITS)) u_ab_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (aidx),
    .rdata_o (a_rdata)
  );

  tbp_ram #(.DW(CTR_W), .AW(INDEX_BITS)) u_gs_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (gidx),
    .rdata_o (g_rdata)
  );

  // Stage 2: predict, grade and train
  ctr_t bc, cc, bc_new, cc_new;
  logic b_pred, g_pred, pred, b_ok, g_ok, f_ok;

  // Take the in-flight write instead of the stale RAM word on a collision.
  assign a_cur = fa_hit_q ? fa_data_q : a_rdata;
  assign g_cur = fg_hit_q ? fg_data_q : g_rdata;

  assign bc     = a_cur[CTR_W-1:0];
  assign cc     = a_cur[AW-1:CTR_W];
  assign b_pred = ctr_pred(bc);
  assign g_pred = ctr_pred(g_cur);
  assign pred   = ctr_pred(cc) ? b_pred : g_pred;
  assign b_ok   = (b_pred == s_taken_q);
  assign g_ok   = (g_pred == s_taken_q);
  assign f_ok   = (pred == s_taken_q);

  always_comb begin
    bc_new = ctr_train(bc, s_taken_q);
    g_new  = ctr_train(g_cur, s_taken_q);
    cc_new = cc;
    // move the chooser only when the components disagree on correctness
    if (b_ok && !g_ok) begin
      cc_new = ctr_train(cc, 1'b1);
    end else if (g_ok && !b_ok) begin
      cc_new = ctr_train(cc, 1'b0);
    end
  end

  assign a_new = {cc_new, bc_new};

  // Write port: clearing pass owns the RAMs until it is done.
  assign a_we    = clearing_q || s_valid_q;
  assign g_we    = clearing_q || s_valid_q;
  assign a_waddr = clearing_q ? clr_idx_q : s_aidx_q;
  assign g_waddr = clearing_q ? clr_idx_q : s_gidx_q;
  assign a_wdata = clearing_q ? {CHOOSE_INIT, DIR_INIT} : a_new;
  assign g_wdata = clearing_q ? DIR_INIT : g_new;

  // Next-state logic
  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + idx_t'(1);
      if (clr_idx_q == '1) begin
        clearing_d = 1'b0;
      end
    end

    hl_d = cfg_we_i ? cfg_wdata_i : hl_q;

    // history advances at accept: the outcome is already known
    hist_d = accept ? MAX_HISTORY'({hist_q, outcome_taken_i}) : hist_q;

    count_d = count_q;
    if (s_valid_q && f_ok && (count_q != '1)) begin
      count_d = count_q + CNT_W'(1);
    end

    s_valid_d = accept;
    done_d    = s_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      hl_q       <= HL_RESET;
      hist_q     <= '0;
      count_q    <= '0;
      s_valid_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
      hl_q       <= hl_d;
      hist_q     <= hist_d;
      count_q    <= count_d;
      s_valid_q  <= s_valid_d;
      done_q     <= done_d;
    end
  end

  // Payload: stage registers, forwarding capture and result fields
  always_ff @(posedge clk_i) begin
    s_aidx_q  <= aidx;
    s_gidx_q  <= gidx;
    s_taken_q <= outcome_taken_i;
    fa_hit_q  <= s_valid_q && (s_aidx_q == aidx);
    fg_hit_q  <= s_valid_q && (s_gidx_q == gidx);
    fa_data_q <= a_new;
    fg_data_q <= g_new;
    pred_q    <= pred;
    final_q   <= f_ok;
    bok_q     <= b_ok;
    gok_q     <= g_ok;
  end

  assign busy_o            = clearing_q;
  assign done_o            = done_q;
  assign predicted_taken_o = pred_q;
  assign final_correct_o   = final_q;
  assign bimodal_correct_o = bok_q;
  assign gshare_correct_o  = gok_q;
  assign correct_total_o   = count_q;

`ifndef ASSERT_OFF
  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_valid_q && !done_q)
    else $error("branch in flight during clearing pass");

  a_done_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |=> done_q)
    else $error("stage beat did not produce a result");

  a_count_holds_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !final_q |-> $stable(count_q))
    else $error("correct count moved on a misprediction");

  a_count_steps_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && final_q && ($past(count_q) != '1) |-> count_q == $past(count_q) + CNT_W'(1))
    else $error("correct count did not advance on a correct prediction");

  a_idle_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q && !$past(s_valid_q) |-> $stable(count_q))
    else $error("correct count moved without a branch");
`endif

endmodule
